FILE: hdl/eht_pkg.sv
// Shared types and codes for the event handle table.
// No dependencies; imported by every module of the block.
package eht_pkg;

  localparam int NUM_EVENTS_DEF       = 64;
  localparam int GRANTS_PER_EVENT_DEF = 8;

  localparam logic [7:0]  KIND_EVENT = 8'h04;
  localparam logic [30:0] GEN_MAX    = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_GRANT   = 3'd2,
    MODE_SIGNAL  = 3'd3,
    MODE_RESET   = 3'd4,
    MODE_POLL    = 3'd5,
    MODE_CLOSE   = 3'd6,
    MODE_RELEASE = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_ALREADY  = 4'd1,
    ST_NOTINIT  = 4'd2,
    ST_INVALID  = 4'd3,
    ST_CAPACITY = 4'd4,
    ST_STALE    = 4'd5,
    ST_DENIED   = 4'd6,
    ST_GRANTED  = 4'd7,
    ST_BLOCK    = 4'd8
  } status_t;

  typedef struct packed {
    logic [30:0] gen;
    logic [15:0] owner;
    logic        auto_reset;
    logic        signaled;
    logic        owner_held;
  } slot_t;

  typedef struct packed {
    logic        open;
    logic [15:0] proc;
  } grant_t;

endpackage

FILE: hdl/eht_grant_find.sv
// Parallel search of one grant row for an open grant held by a process.
// Depends on eht_pkg for the grant entry type.
module eht_grant_find import eht_pkg::*; #(
  parameter int GRANTS_PER_EVENT = GRANTS_PER_EVENT_DEF
) (
  input  grant_t [GRANTS_PER_EVENT-1:0] row,
  input  logic [15:0]                   key,
  output logic                          hit,
  output logic [GRANTS_PER_EVENT-1:0]   first
);

  always_comb begin
    logic found;
    found = 1'b0;
    first = '0;
    for (int i = 0; i < GRANTS_PER_EVENT; i++) begin
      if (!found && row[i].open && row[i].proc == key) begin
        first[i] = 1'b1;
        found    = 1'b1;
      end
    end
    hit = found;
  end

endmodule

FILE: hdl/event_handle_table_unit.sv
// Event handle table: slot and grant memories with a read-modify-write sequencer.
// Depends on eht_pkg and eht_grant_find.
//
// Usage: one request enters on the in_ channel (valid/ready) and exactly one
// result leaves on the out_ channel (valid/ready). Requests are handled one
// at a time; in_ready is high whenever the sequencer is idle, even while the
// previous result still sits in the output register.
// Path from accept to out_valid, through the states:
//   init, not-ready and argument errors: straight to the final state
//   signal, reset, poll, close, grant: read, execute, result
//   create: scan up to the first free slot, then execute and result
//   release: one read and one execute per slot, then result
// Reads of the slot and grant memories are registered, and create and
// release walk the slots.
// Reset clears the ready flag and the per-slot valid and active bits at once;
// the memories need no clearing pass, since a row not written since init
// reads as zero. Init likewise clears the valid bits.
// If the receiver stalls, the finished result waits in a final state until
// the output register frees up; no result is lost or repeated.
module event_handle_table_unit import eht_pkg::*; #(
  parameter int NUM_EVENTS       = NUM_EVENTS_DEF,
  parameter int GRANTS_PER_EVENT = GRANTS_PER_EVENT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_pid,
  input  logic [15:0] in_target_pid,
  input  logic [63:0] in_event_handle,
  input  logic        in_auto_reset,
  input  logic        in_initially_signaled,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [63:0] out_new_handle
);

  localparam int IW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_EVENTS - 1);
  localparam logic [7:0]    NUM_ENC  = 8'(NUM_EVENTS);

  typedef grant_t [GRANTS_PER_EVENT-1:0] row_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CR_EX, S_RD, S_EX, S_REL_RD, S_REL_EX, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic            ready_r, ready_nxt;
  logic [NUM_EVENTS-1:0] active_r, active_nxt;
  logic [NUM_EVENTS-1:0] slot_vld_r, slot_vld_nxt;
  logic [NUM_EVENTS-1:0] row_vld_r, row_vld_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  mode_t           mode_r, mode_nxt;
  logic [15:0]     pid_r, pid_nxt;
  logic [15:0]     tpid_r, tpid_nxt;
  logic [63:0]     h_r, h_nxt;
  logic            ar_r, ar_nxt;
  logic            sig_r, sig_nxt;
  status_t         st_r, st_nxt;
  logic [63:0]     nh_r, nh_nxt;
  logic            out_valid_r;
  status_t         out_status_r;
  logic [63:0]     out_nh_r;

  slot_t slot_mem [NUM_EVENTS];
  row_t  grant_mem [NUM_EVENTS];
  slot_t slot_q_r;
  row_t  row_q_r;
  slot_t slot_d, slot_wd;
  row_t  row_d, row_wd;
  logic  slot_we, row_we;

  logic                        pid_hit, tpid_hit;
  logic [GRANTS_PER_EVENT-1:0] pid_first, tpid_first;
  logic [GRANTS_PER_EVENT-1:0] free_first;
  logic                        free_any;

  logic [7:0]    enc;
  logic [IW-1:0] dec_idx;
  logic          dec_ok;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_handle = out_nh_r;

  assign slot_d = slot_vld_r[idx_r] ? slot_q_r : '0;
  assign row_d  = row_vld_r[idx_r] ? row_q_r : '0;

  eht_grant_find #(.GRANTS_PER_EVENT(GRANTS_PER_EVENT)) u_find_pid (
    .row(row_d), .key(pid_r), .hit(pid_hit), .first(pid_first)
  );

  eht_grant_find #(.GRANTS_PER_EVENT(GRANTS_PER_EVENT)) u_find_tpid (
    .row(row_d), .key(tpid_r), .hit(tpid_hit), .first(tpid_first)
  );

  always_comb begin
    logic found;
    found      = 1'b0;
    free_first = '0;
    for (int i = 0; i < GRANTS_PER_EVENT; i++) begin
      if (!found && !row_d[i].open) begin
        free_first[i] = 1'b1;
        found         = 1'b1;
      end
    end
    free_any = found;
  end

  // Handle decode on the incoming item: kind byte, index range, active slot.
  assign enc     = in_event_handle[7:0];
  assign dec_idx = IW'(enc - 8'd1);
  assign dec_ok  = (in_event_handle[23:16] == KIND_EVENT) && (enc != 8'd0) &&
                   (enc <= NUM_ENC) && active_r[dec_idx];

  always_comb begin
    slot_t       ns;
    row_t        nr;
    logic [30:0] gnew;
    logic        any_open;
    logic        upd;

    state_nxt    = state_r;
    ready_nxt    = ready_r;
    active_nxt   = active_r;
    slot_vld_nxt = slot_vld_r;
    row_vld_nxt  = row_vld_r;
    idx_nxt      = idx_r;
    mode_nxt     = mode_r;
    pid_nxt      = pid_r;
    tpid_nxt     = tpid_r;
    h_nxt        = h_r;
    ar_nxt       = ar_r;
    sig_nxt      = sig_r;
    st_nxt       = st_r;
    nh_nxt       = nh_r;
    slot_we      = 1'b0;
    row_we       = 1'b0;
    slot_wd      = slot_d;
    row_wd       = row_d;
    ns           = slot_d;
    nr           = row_d;
    upd          = 1'b0;
    gnew         = '0;
    any_open     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = mode_t'(in_mode);
          pid_nxt   = in_pid;
          tpid_nxt  = in_target_pid;
          h_nxt     = in_event_handle;
          ar_nxt    = in_auto_reset;
          sig_nxt   = in_initially_signaled;
          nh_nxt    = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
          if (mode_t'(in_mode) == MODE_INIT) begin
            if (ready_r) begin
              st_nxt = ST_ALREADY;
            end else begin
              ready_nxt    = 1'b1;
              active_nxt   = '0;
              slot_vld_nxt = '0;
              row_vld_nxt  = '0;
            end
          end else if (mode_t'(in_mode) == MODE_RELEASE) begin
            if (ready_r && in_pid != 16'd0) begin
              idx_nxt   = '0;
              state_nxt = S_REL_RD;
            end
          end else if (!ready_r) begin
            st_nxt = ST_NOTINIT;
          end else if (mode_t'(in_mode) == MODE_CREATE) begin
            if (in_pid == 16'd0) begin
              st_nxt = ST_INVALID;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end else if (in_pid == 16'd0 ||
                       (mode_t'(in_mode) == MODE_GRANT &&
                        (in_target_pid == 16'd0 || in_target_pid == in_pid))) begin
            st_nxt = ST_INVALID;
          end else if (!dec_ok) begin
            st_nxt = ST_STALE;
          end else begin
            idx_nxt   = dec_idx;
            state_nxt = S_RD;
          end
        end
      end

      S_SCAN: begin
        if (!active_r[idx_r]) begin
          state_nxt = S_CR_EX;
        end else if (idx_r == LAST_IDX) begin
          st_nxt    = ST_CAPACITY;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_CR_EX: begin
        gnew = (slot_d.gen == 31'd0 || slot_d.gen >= GEN_MAX) ? 31'd1 : slot_d.gen + 31'd1;
        slot_we      = 1'b1;
        slot_wd      = '{gen: gnew, owner: pid_r, auto_reset: ar_r,
                         signaled: sig_r, owner_held: 1'b1};
        slot_vld_nxt[idx_r] = 1'b1;
        active_nxt[idx_r]   = 1'b1;
        row_vld_nxt[idx_r]  = 1'b0;
        nh_nxt    = {1'b0, gnew, 8'h00, KIND_EVENT, 8'h00, 8'(idx_r) + 8'd1};
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
      end

      S_RD: begin
        state_nxt = S_EX;
      end

      S_EX: begin
        state_nxt = S_DONE;
        if (h_r[63:32] != {1'b0, slot_d.gen}) begin
          st_nxt = ST_STALE;
        end else begin
          unique case (mode_r) inside
            MODE_GRANT: begin
              if (!(slot_d.owner == pid_r && slot_d.owner_held)) begin
                st_nxt = ST_DENIED;
              end else if (tpid_hit) begin
                st_nxt = ST_GRANTED;
              end else if (!free_any) begin
                st_nxt = ST_CAPACITY;
              end else begin
                for (int i = 0; i < GRANTS_PER_EVENT; i++) begin
                  if (free_first[i]) nr[i] = '{open: 1'b1, proc: tpid_r};
                end
                upd = 1'b1;
              end
            end
            MODE_CLOSE: begin
              if (slot_d.owner == pid_r && slot_d.owner_held) begin
                ns.owner_held = 1'b0;
                upd = 1'b1;
              end else if (pid_hit) begin
                for (int i = 0; i < GRANTS_PER_EVENT; i++) begin
                  if (pid_first[i]) nr[i] = '0;
                end
                upd = 1'b1;
              end else begin
                st_nxt = ST_DENIED;
              end
            end
            MODE_SIGNAL, MODE_RESET, MODE_POLL: begin
              if (!((slot_d.owner == pid_r && slot_d.owner_held) || pid_hit)) begin
                st_nxt = ST_DENIED;
              end else if (mode_r == MODE_SIGNAL) begin
                ns.signaled = 1'b1;
                upd = 1'b1;
              end else if (mode_r == MODE_RESET) begin
                ns.signaled = 1'b0;
                upd = 1'b1;
              end else if (!slot_d.signaled) begin
                st_nxt = ST_BLOCK;
              end else if (slot_d.auto_reset) begin
                ns.signaled = 1'b0;
                upd = 1'b1;
              end
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end

      S_REL_RD: begin
        state_nxt = S_REL_EX;
      end

      S_REL_EX: begin
        if (active_r[idx_r]) begin
          if (slot_d.owner == pid_r) ns.owner_held = 1'b0;
          for (int i = 0; i < GRANTS_PER_EVENT; i++) begin
            if (row_d[i].open && row_d[i].proc == pid_r) nr[i] = '0;
          end
          upd = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_REL_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Write back the modified slot; free it when no reference stays open.
    if (upd) begin
      for (int i = 0; i < GRANTS_PER_EVENT; i++) begin
        any_open = any_open | nr[i].open;
      end
      slot_we             = 1'b1;
      slot_vld_nxt[idx_r] = 1'b1;
      if (!ns.owner_held && !any_open) begin
        slot_wd            = '{gen: slot_d.gen, owner: 16'd0, auto_reset: 1'b0,
                               signaled: 1'b0, owner_held: 1'b0};
        active_nxt[idx_r]  = 1'b0;
        row_vld_nxt[idx_r] = 1'b0;
      end else begin
        slot_wd            = ns;
        row_we             = 1'b1;
        row_wd             = nr;
        row_vld_nxt[idx_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[idx_r] <= slot_wd;
    if (row_we) grant_mem[idx_r] <= row_wd;
    slot_q_r <= slot_mem[idx_r];
    row_q_r  <= grant_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      active_r    <= '0;
      slot_vld_r  <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ready_r    <= ready_nxt;
      active_r   <= active_nxt;
      slot_vld_r <= slot_vld_nxt;
      row_vld_r  <= row_vld_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    mode_r <= mode_nxt;
    pid_r  <= pid_nxt;
    tpid_r <= tpid_nxt;
    h_r    <= h_nxt;
    ar_r   <= ar_nxt;
    sig_r  <= sig_nxt;
    st_r   <= st_nxt;
    nh_r   <= nh_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_status_r <= st_r;
      out_nh_r     <= nh_r;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in progress");

  a_err_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_new_handle == 64'd0)
    else $error("failing request returned a handle");

  a_handle_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_handle != 64'd0 |-> out_new_handle[23:16] == KIND_EVENT)
    else $error("new handle has wrong kind byte");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |-> state_r == S_CR_EX || state_r == S_EX || state_r == S_REL_EX)
    else $error("slot memory written outside an execute state");

  a_find_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EX |-> $onehot0(pid_first) && $onehot0(tpid_first) &&
                        (tpid_hit == (|tpid_first)))
    else $error("grant search returned more than one match");

endmodule

FILE: bench/event_handle_table_unit_tb.sv
// Self-checking bench for event_handle_table_unit: directed and random requests
// against a behavioral model of the handle table, results compared in order.
// Depends on eht_pkg and the event_handle_table_unit RTL.
`timescale 1ns / 1ps

module event_handle_table_unit_tb import eht_pkg::*; ();

  localparam int NEV = NUM_EVENTS_DEF;
  localparam int NGR = GRANTS_PER_EVENT_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [63:0] KIND_BITS = 64'(KIND_EVENT) << 16;

  typedef struct packed {
    status_t     status;
    logic [63:0] handle;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [15:0] in_pid = '0;
  logic [15:0] in_target_pid = '0;
  logic [63:0] in_event_handle = '0;
  logic        in_auto_reset = 1'b0;
  logic        in_initially_signaled = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_status;
  logic [63:0] out_new_handle;

  event_handle_table_unit dut (.*);

  always #5 clk = ~clk;

  // table model
  bit          tbl_ready;
  logic [30:0] tbl_gen [NEV];
  logic [15:0] tbl_owner [NEV];
  bit          tbl_auto [NEV];
  bit          tbl_sig [NEV];
  bit          tbl_oopen [NEV];
  bit          tbl_active [NEV];
  logic [15:0] gr_proc [NEV][NGR];
  bit          gr_open [NEV][NGR];

  answer_t     pending_answers [$];
  logic [63:0] live_handles [$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet_tail = 0;
  bit          rx_hold = 0;
  int          rx_hold_cycles = 0;
  int          rx_idle = 0;

  function automatic void wipe_slot(int s, bit keep_gen);
    if (!keep_gen) tbl_gen[s] = '0;
    tbl_owner[s] = '0;
    tbl_auto[s] = 0;
    tbl_sig[s] = 0;
    tbl_oopen[s] = 0;
    tbl_active[s] = 0;
    for (int g = 0; g < NGR; g++) begin
      gr_proc[s][g] = '0;
      gr_open[s][g] = 0;
    end
  endfunction

  function automatic int grant_of(int s, logic [15:0] p);
    for (int g = 0; g < NGR; g++)
      if (gr_open[s][g] && gr_proc[s][g] == p) return g;
    return -1;
  endfunction

  function automatic void free_if_unused(int s);
    if (!tbl_active[s] || tbl_oopen[s]) return;
    for (int g = 0; g < NGR; g++) if (gr_open[s][g]) return;
    wipe_slot(s, 1);
  endfunction

  function automatic status_t lookup(logic [63:0] h, output int s);
    int enc;
    s = 0;
    if (h[23:16] != KIND_EVENT) return ST_STALE;
    enc = h[7:0];
    if (enc == 0 || enc > NEV) return ST_STALE;
    s = enc - 1;
    if (!tbl_active[s] || {1'b0, tbl_gen[s]} != h[63:32]) return ST_STALE;
    return ST_OK;
  endfunction

  function automatic answer_t table_answer(mode_t m, logic [15:0] p, logic [15:0] tp,
                                           logic [63:0] h, bit ar, bit sg);
    answer_t a;
    int s, gi;
    logic [30:0] ng;
    a.status = ST_OK;
    a.handle = '0;
    if (m == MODE_INIT) begin
      if (tbl_ready) a.status = ST_ALREADY;
      else begin
        for (int i = 0; i < NEV; i++) wipe_slot(i, 0);
        tbl_ready = 1;
      end
    end else if (m == MODE_RELEASE) begin
      if (tbl_ready && p != 0) begin
        for (int i = 0; i < NEV; i++) begin
          if (!tbl_active[i]) continue;
          if (tbl_owner[i] == p) tbl_oopen[i] = 0;
          for (int g = 0; g < NGR; g++)
            if (gr_open[i][g] && gr_proc[i][g] == p) begin
              gr_open[i][g] = 0;
              gr_proc[i][g] = '0;
            end
          free_if_unused(i);
        end
      end
    end else if (!tbl_ready) a.status = ST_NOTINIT;
    else if (m == MODE_CREATE) begin
      if (p == 0) a.status = ST_INVALID;
      else begin
        a.status = ST_CAPACITY;
        for (int i = 0; i < NEV; i++) begin
          if (tbl_active[i]) continue;
          ng = (tbl_gen[i] == 0 || tbl_gen[i] == GEN_MAX) ? 31'd1 : tbl_gen[i] + 31'd1;
          wipe_slot(i, 0);
          tbl_gen[i] = ng;
          tbl_owner[i] = p;
          tbl_auto[i] = ar;
          tbl_sig[i] = sg;
          tbl_oopen[i] = 1;
          tbl_active[i] = 1;
          a.handle = {1'b0, ng, 32'd0} | KIND_BITS | 64'(i + 1);
          a.status = ST_OK;
          break;
        end
      end
    end else if (m == MODE_GRANT) begin
      if (p == 0 || tp == 0 || p == tp) a.status = ST_INVALID;
      else begin
        a.status = lookup(h, s);
        if (a.status == ST_OK) begin
          if (tbl_owner[s] != p || !tbl_oopen[s]) a.status = ST_DENIED;
          else if (grant_of(s, tp) >= 0) a.status = ST_GRANTED;
          else begin
            a.status = ST_CAPACITY;
            for (int g = 0; g < NGR; g++)
              if (!gr_open[s][g]) begin
                gr_proc[s][g] = tp;
                gr_open[s][g] = 1;
                a.status = ST_OK;
                break;
              end
          end
        end
      end
    end else if (p == 0) a.status = ST_INVALID;
    else begin
      a.status = lookup(h, s);
      if (a.status == ST_OK) begin
        if (m == MODE_CLOSE) begin
          if (tbl_owner[s] == p && tbl_oopen[s]) begin
            tbl_oopen[s] = 0;
            free_if_unused(s);
          end else begin
            gi = grant_of(s, p);
            if (gi < 0) a.status = ST_DENIED;
            else begin
              gr_open[s][gi] = 0;
              gr_proc[s][gi] = '0;
              free_if_unused(s);
            end
          end
        end else if (!((tbl_owner[s] == p && tbl_oopen[s]) || grant_of(s, p) >= 0))
          a.status = ST_DENIED;
        else if (m == MODE_SIGNAL) tbl_sig[s] = 1;
        else if (m == MODE_RESET) tbl_sig[s] = 0;
        else if (!tbl_sig[s]) a.status = ST_BLOCK;
        else if (tbl_auto[s]) tbl_sig[s] = 0;
      end
    end
    return a;
  endfunction

  // Send one item; predict at acceptance. Valid stays up into the next call
  // unless that call idles first.
  task automatic send_request(mode_t m, logic [15:0] p, logic [15:0] tp = 0,
                              logic [63:0] h = 0, bit ar = 0, bit sg = 0);
    answer_t a;
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_pid <= p;
    in_target_pid <= tp;
    in_event_handle <= h;
    in_auto_reset <= ar;
    in_initially_signaled <= sg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    a = table_answer(m, p, tp, h, ar, sg);
    pending_answers.push_back(a);
    if (m == MODE_CREATE && a.status == ST_OK) live_handles.push_back(a.handle);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2 * NEV + 10) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    answer_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected result status=%0d", out_status);
      end else begin
        e = pending_answers.pop_front();
        if (out_status !== e.status || out_new_handle !== e.handle) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: status exp %0d got %0d, handle exp %h got %h",
                     e.status, out_status, e.handle, out_new_handle);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rx_hold) begin
      out_ready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles + 1;
      if (rx_hold_cycles >= 300) rx_hold <= 0;
    end else if (quiet_tail) out_ready <= 1'b1;
    else if (rx_idle > 0) begin
      out_ready <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_idle <= $urandom_range(0, 6);
    end else out_ready <= 1'b1;
  end

  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end

  function automatic logic [15:0] pick_pid();
    return $urandom_range(0, 15) == 0 ? 16'(0) :
           ($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 6)));
  endfunction

  function automatic logic [63:0] pick_handle();
    logic [63:0] h;
    int r;
    r = $urandom_range(0, 9);
    if (live_handles.size() != 0 && r < 7)
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
    else if (r < 9)
      h = KIND_BITS | 64'($urandom_range(0, NEV + 2)) |
          (64'($urandom_range(0, 3)) << 32);
    else h = {$urandom, $urandom};
    // noise in ignored bits, and occasional gen corruption
    if ($urandom_range(0, 3) == 0) h[15:8] = 8'($urandom);
    if ($urandom_range(0, 3) == 0) h[31:24] = 8'($urandom);
    if ($urandom_range(0, 15) == 0) h[63] = ~h[63];
    return h;
  endfunction

  task automatic test_not_ready();
    send_request(MODE_CREATE, 1);
    send_request(MODE_POLL, 1, 0, KIND_BITS | 1);
    send_request(MODE_RELEASE, 1);
    send_request(MODE_INIT, 0);
    send_request(MODE_INIT, 0);
  endtask

  task automatic test_directed();
    logic [63:0] h;
    send_request(MODE_CREATE, 0);
    send_request(MODE_CREATE, 16'hFFFF, 0, 0, 1, 1);
    h = live_handles[$];
    send_request(MODE_POLL, 16'hFFFF, 0, h);
    send_request(MODE_POLL, 16'hFFFF, 0, h);
    send_request(MODE_GRANT, 16'hFFFF, 16'hFFFF, h);
    send_request(MODE_GRANT, 16'hFFFF, 0, h);
    send_request(MODE_GRANT, 16'd5, 16'd7, h);
    send_request(MODE_GRANT, 16'hFFFF, 16'd7, h);
    send_request(MODE_GRANT, 16'hFFFF, 16'd7, h);
    send_request(MODE_SIGNAL, 16'd7, 0, h);
    send_request(MODE_RESET, 16'd9, 0, h);
    send_request(MODE_POLL, 0, 0, h);
    send_request(MODE_SIGNAL, 16'd7, 0, h ^ (64'd1 << 32));
    send_request(MODE_SIGNAL, 16'd7, 0, h & ~KIND_BITS);
    send_request(MODE_CLOSE, 16'hFFFF, 0, h);
    send_request(MODE_CLOSE, 16'd9, 0, h);
    send_request(MODE_CLOSE, 16'd7, 0, h);
    send_request(MODE_POLL, 16'd7, 0, h);
    send_request(MODE_SIGNAL, 16'd1, 0, KIND_BITS | 64'(NEV + 1));
    send_request(MODE_RELEASE, 0);
    drain_results();
  endtask

  // Fill the table, exhaust grants of one slot, then release the owner and one grantee.
  task automatic test_capacity();
    for (int i = 0; i <= NEV; i++) send_request(MODE_CREATE, 16'd3, 0, 0, i[0], i[1]);
    for (int g = 0; g <= NGR; g++) send_request(MODE_GRANT, 16'd3, 16'(10 + g), live_handles[$]);
    send_request(MODE_RELEASE, 16'd3);
    send_request(MODE_RELEASE, 16'd10);
    drain_results();
    live_handles.delete();
  endtask

  task automatic test_random(int n);
    int r;
    mode_t m;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        rx_hold_cycles <= 0;
        rx_hold <= 1;
      end
      if (i == 2 * n / 3) drain_results();
      if (i == n - 200) quiet_tail = 1;
      if (live_handles.size() > 40) void'(live_handles.pop_front());
      r = $urandom_range(0, 99);
      m = r < 18 ? MODE_CREATE : r < 32 ? MODE_GRANT : r < 46 ? MODE_SIGNAL :
          r < 56 ? MODE_RESET : r < 72 ? MODE_POLL : r < 90 ? MODE_CLOSE :
          r < 97 ? MODE_RELEASE : MODE_INIT;
      send_request(m, pick_pid(), $urandom_range(0, 7) == 0 ? 16'($urandom) :
                   16'($urandom_range(0, 6)), pick_handle(), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NEV; i++) wipe_slot(i, 0);
    tbl_ready = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_ready();
    test_directed();
    test_capacity();
    test_random(1800);
    drain_results();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: event_handle_table_unit.f
hdl/eht_pkg.sv
hdl/eht_grant_find.sv
hdl/event_handle_table_unit.sv
bench/event_handle_table_unit_tb.sv
